// ===== sv/mt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt_pkg
// constants, function codes and word functions for the mt19937 generator
// ----------------------------------------------------------------------------
package mt_pkg;

    localparam int STATE_DEPTH = 624;
    localparam int TAP_OFFSET  = 397;
    localparam int IDX_W       = 10;

    localparam logic [31:0] TWIST_MATRIX    = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT        = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS        = 32'h7fff_ffff;
    localparam logic [31:0] SEED_MULT       = 32'd1812433253;
    localparam logic [31:0] ARRAY_MULT_A    = 32'd1664525;
    localparam logic [31:0] ARRAY_MULT_B    = 32'd1566083941;
    localparam logic [31:0] TEMPER_B        = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C        = 32'hefc6_0000;
    localparam logic [31:0] DEFAULT_SEED    = 32'd5489;
    localparam logic [31:0] ARRAY_BASE_SEED = 32'd19650218;

    localparam logic [1:0] FUNC_SEED   = 2'd0;
    localparam logic [1:0] FUNC_DRAW   = 2'd1;
    localparam logic [1:0] FUNC_KEY    = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = {32'd0, a} * {32'd0, b};
        return prod[31:0];
    endfunction

    function automatic logic [31:0] fold30(input logic [31:0] p);
        return p ^ (p >> 30);
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== sv/mt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/mersenne_twister_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne_twister_generator_top
// mt19937 generator with word seeding, keyed array seeding and tempered draws
// ----------------------------------------------------------------------------
// channel   direction  ports                                        handshake
// command   in         func, seed_value, key_word, key_last         start & !busy
// result    out        random_word, key_dropped                     done strobe
//
// a draw within the current block of 624 words keeps busy for a ram read and the temper;
// the draw that finds the block exhausted regenerates it first, word by word; one
// ram read port serves the three reads of each word; a first draw with no seed
// seeds with the default seed first. func 0 seeds the state; a key word but the
// last leaves busy low; the last key word seeds, runs two mixing passes, a final write.
// reset clears all registers but not the ram contents; the result cannot be stalled.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_top #(
    parameter int KEY_MAX = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] seed_value,
    input  logic [31:0] key_word,
    input  logic        key_last,
    output logic        done,
    output logic [31:0] random_word,
    output logic        key_dropped
);

    localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KCW = $clog2(KEY_MAX + 1);
    localparam int IW  = mt_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX  = IW'(mt_pkg::STATE_DEPTH - 1);
    localparam logic [IW-1:0] TAP_SPLIT = IW'(mt_pkg::STATE_DEPTH - mt_pkg::TAP_OFFSET);
    localparam logic [IW-1:0] DEPTH_IDX = IW'(mt_pkg::STATE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEED, ST_RG0, ST_RG1, ST_RG2, ST_RG3, ST_DRAW_RD, ST_DRAW_OUT,
        ST_A1_RD, ST_A1_WR, ST_A2_RD, ST_A2_WR, ST_FIN
    } state_t;

    state_t          state_reg;
    logic [1:0]      mode_reg;
    logic [IW-1:0]   n_reg;
    logic [IW-1:0]   k_reg;
    logic [KAW-1:0]  j_reg;
    logic [KCW-1:0]  len_reg;
    logic [KCW-1:0]  key_count_reg;
    logic [IW-1:0]   draw_index_reg;
    logic            seeded_reg;
    logic            drop_reg;
    logic [31:0]     p_reg;
    logic [31:0]     a_reg;
    logic [31:0]     b_reg;
    logic            done_reg;
    logic [31:0]     random_word_reg;
    logic            key_dropped_reg;

    logic            tw_we;
    logic [IW-1:0]   tw_waddr;
    logic [31:0]     tw_wdata;
    logic [IW-1:0]   tw_raddr;
    logic [31:0]     tw_rdata;
    logic            key_we;
    logic [KAW-1:0]  key_raddr;
    logic [31:0]     key_rdata;

    logic            accept;
    logic [IW-1:0]   nxt_idx;
    logic [IW-1:0]   tap_idx;
    logic [IW-1:0]   i_step;
    logic [KCW-1:0]  j_inc;
    logic [KCW-1:0]  count_after;
    logic [31:0]     seed_next;
    logic [31:0]     regen_y;
    logic [31:0]     regen_word;
    logic [31:0]     a1_word;
    logic [31:0]     a2_word;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    assign nxt_idx = (n_reg == LAST_IDX) ? '0 : n_reg + 1'b1;
    assign tap_idx = (n_reg < TAP_SPLIT) ? n_reg + IW'(mt_pkg::TAP_OFFSET)
                                         : n_reg - TAP_SPLIT;
    // array seeding skips index 0 on wrap
    assign i_step  = (n_reg == LAST_IDX) ? IW'(1) : n_reg + 1'b1;
    assign j_inc   = KCW'(j_reg) + 1'b1;
    assign count_after = (key_count_reg < KCW'(KEY_MAX)) ? key_count_reg + 1'b1
                                                          : key_count_reg;

    assign seed_next = mt_pkg::mul32(mt_pkg::SEED_MULT, mt_pkg::fold30(p_reg))
                     + 32'(n_reg);
    assign regen_y   = (a_reg & mt_pkg::HIGH_BIT) | (b_reg & mt_pkg::LOW_BITS);
    assign regen_word = tw_rdata ^ (regen_y >> 1)
                      ^ (regen_y[0] ? mt_pkg::TWIST_MATRIX : 32'd0);
    assign a1_word = (tw_rdata ^ mt_pkg::mul32(mt_pkg::fold30(p_reg), mt_pkg::ARRAY_MULT_A))
                   + key_rdata + 32'(j_reg);
    assign a2_word = (tw_rdata ^ mt_pkg::mul32(mt_pkg::fold30(p_reg), mt_pkg::ARRAY_MULT_B))
                   - 32'(n_reg);

    always_comb
    begin
        tw_we    = 1'b0;
        tw_waddr = n_reg;
        tw_wdata = regen_word;
        tw_raddr = n_reg;
        unique case (state_reg)
            ST_SEED:
            begin
                tw_we    = 1'b1;
                tw_wdata = (n_reg == '0) ? p_reg : seed_next;
            end
            ST_RG1:     tw_raddr = nxt_idx;
            ST_RG2:     tw_raddr = tap_idx;
            ST_RG3:     tw_we = 1'b1;
            ST_DRAW_RD: tw_raddr = draw_index_reg;
            ST_A1_WR:
            begin
                tw_we    = 1'b1;
                tw_wdata = a1_word;
            end
            ST_A2_WR:
            begin
                tw_we    = 1'b1;
                tw_wdata = a2_word;
            end
            ST_FIN:
            begin
                tw_we    = 1'b1;
                tw_waddr = '0;
                tw_wdata = mt_pkg::HIGH_BIT;
            end
            default:    tw_we = 1'b0;
        endcase
    end

    assign key_we    = accept && (func == mt_pkg::FUNC_KEY)
                    && (key_count_reg < KCW'(KEY_MAX));
    assign key_raddr = j_reg;

    mt_ram #(.WIDTH(32), .DEPTH(mt_pkg::STATE_DEPTH)) u_tw_ram (
        .clk   (clk),
        .we    (tw_we),
        .waddr (tw_waddr),
        .wdata (tw_wdata),
        .raddr (tw_raddr),
        .rdata (tw_rdata)
    );

    mt_ram #(.WIDTH(32), .DEPTH(KEY_MAX)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_count_reg[KAW-1:0]),
        .wdata (key_word),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= mt_pkg::FUNC_SEED;
            n_reg           <= '0;
            k_reg           <= '0;
            j_reg           <= '0;
            len_reg         <= '0;
            key_count_reg   <= '0;
            draw_index_reg  <= DEPTH_IDX;
            seeded_reg      <= 1'b0;
            drop_reg        <= 1'b0;
            p_reg           <= '0;
            a_reg           <= '0;
            b_reg           <= '0;
            done_reg        <= 1'b0;
            random_word_reg <= '0;
            key_dropped_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= func;
                        n_reg    <= '0;
                        drop_reg <= 1'b0;
                        case (func)
                            mt_pkg::FUNC_SEED:
                            begin
                                p_reg     <= seed_value;
                                state_reg <= ST_SEED;
                            end
                            mt_pkg::FUNC_DRAW:
                            begin
                                if (draw_index_reg >= DEPTH_IDX)
                                begin
                                    p_reg     <= mt_pkg::DEFAULT_SEED;
                                    state_reg <= seeded_reg ? ST_RG0 : ST_SEED;
                                end
                                else
                                begin
                                    state_reg <= ST_DRAW_RD;
                                end
                            end
                            mt_pkg::FUNC_KEY:
                            begin
                                drop_reg      <= !(key_count_reg < KCW'(KEY_MAX));
                                if (key_last && (count_after != '0))
                                begin
                                    len_reg       <= count_after;
                                    key_count_reg <= '0;
                                    p_reg         <= mt_pkg::ARRAY_BASE_SEED;
                                    state_reg     <= ST_SEED;
                                end
                                else
                                begin
                                    key_count_reg   <= count_after;
                                    done_reg        <= 1'b1;
                                    random_word_reg <= '0;
                                    key_dropped_reg <= !(key_count_reg < KCW'(KEY_MAX));
                                end
                            end
                            default:
                            begin
                                done_reg        <= 1'b1;
                                random_word_reg <= '0;
                                key_dropped_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_SEED:
                begin
                    // key mixing starts from word 0, the base seed
                    if ((n_reg == LAST_IDX) && (mode_reg == mt_pkg::FUNC_KEY))
                    begin
                        p_reg <= mt_pkg::ARRAY_BASE_SEED;
                    end
                    else if (n_reg != '0)
                    begin
                        p_reg <= seed_next;
                    end
                    if (n_reg == LAST_IDX)
                    begin
                        seeded_reg <= 1'b1;
                        case (mode_reg)
                            mt_pkg::FUNC_DRAW:
                            begin
                                n_reg     <= '0;
                                state_reg <= ST_RG0;
                            end
                            mt_pkg::FUNC_KEY:
                            begin
                                n_reg     <= IW'(1);
                                k_reg     <= '0;
                                j_reg     <= '0;
                                state_reg <= ST_A1_RD;
                            end
                            default:
                            begin
                                draw_index_reg  <= DEPTH_IDX;
                                done_reg        <= 1'b1;
                                random_word_reg <= '0;
                                key_dropped_reg <= 1'b0;
                                state_reg       <= ST_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        n_reg <= n_reg + 1'b1;
                    end
                end
                ST_RG0: state_reg <= ST_RG1;
                ST_RG1:
                begin
                    a_reg     <= tw_rdata;
                    state_reg <= ST_RG2;
                end
                ST_RG2:
                begin
                    b_reg     <= tw_rdata;
                    state_reg <= ST_RG3;
                end
                ST_RG3:
                begin
                    if (n_reg == LAST_IDX)
                    begin
                        draw_index_reg <= '0;
                        state_reg      <= ST_DRAW_RD;
                    end
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= ST_RG0;
                    end
                end
                ST_DRAW_RD: state_reg <= ST_DRAW_OUT;
                ST_DRAW_OUT:
                begin
                    draw_index_reg  <= draw_index_reg + 1'b1;
                    done_reg        <= 1'b1;
                    random_word_reg <= mt_pkg::temper(tw_rdata);
                    key_dropped_reg <= 1'b0;
                    state_reg       <= ST_IDLE;
                end
                ST_A1_RD: state_reg <= ST_A1_WR;
                ST_A1_WR:
                begin
                    p_reg <= a1_word;
                    n_reg <= i_step;
                    j_reg <= (j_inc >= len_reg) ? '0 : j_reg + 1'b1;
                    if (k_reg == LAST_IDX)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_A2_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_A1_RD;
                    end
                end
                ST_A2_RD: state_reg <= ST_A2_WR;
                ST_A2_WR:
                begin
                    p_reg <= a2_word;
                    n_reg <= i_step;
                    k_reg <= k_reg + 1'b1;
                    // one fewer pass than the word count
                    state_reg <= (k_reg == LAST_IDX - 1'b1) ? ST_FIN : ST_A2_RD;
                end
                ST_FIN:
                begin
                    seeded_reg      <= 1'b1;
                    draw_index_reg  <= DEPTH_IDX;
                    done_reg        <= 1'b1;
                    random_word_reg <= '0;
                    key_dropped_reg <= drop_reg;
                    state_reg       <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done        = done_reg;
    assign random_word = random_word_reg;
    assign key_dropped = key_dropped_reg;

endmodule
